[hdl/teg_pkg.sv]
package teg_pkg;

    localparam int NUM_BITS      = 12;
    localparam int QUEUE_DEPTH   = 4;
    localparam int PEND_BITS     = 2 * NUM_BITS;
    localparam int PEND_IDX_W    = $clog2(PEND_BITS);
    localparam int ADDR_W        = 6;
    localparam int DATA_W        = 64;

    localparam logic [NUM_BITS-1:0] DEFAULT_NOMINAL = 12'h0a95;
    localparam logic [NUM_BITS-1:0] BITS_MASK       = 12'h0fff;
    localparam logic [15:0]         NO_OVERRIDE     = 16'hFFFF;

    localparam logic [47:0] LEVELS_RESET   = 48'hFFFFFF000000;

    localparam logic OP_UPDATE    = 1'b0;
    localparam logic OP_REARM     = 1'b1;
    localparam logic KIND_EVENT   = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;
    localparam logic DIR_ASSERT   = 1'b0;
    localparam logic DIR_DEASSERT = 1'b1;

    typedef enum logic [2:0] {
        REG_THRESHOLD_LEVELS   = 3'd0,
        REG_HYST_LOW           = 3'd1,
        REG_HYST_HIGH          = 3'd2,
        REG_NOMINAL_OVERRIDE   = 3'd3,
        REG_NOMINAL_READING    = 3'd4,
        REG_NOMINAL_KNOWN      = 3'd5,
        REG_ASSERT_SEND_MASK   = 3'd6,
        REG_DEASSERT_SEND_MASK = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic                opcode;
        logic [7:0]          reading;
        logic                reading_valid;
        logic [NUM_BITS-1:0] context_request;
        logic [NUM_BITS-1:0] force_assert;
        logic [NUM_BITS-1:0] force_deassert;
    } sample_t;

    typedef struct packed {
        logic                kind;
        logic [3:0]          event_offset;
        logic                direction;
        logic [7:0]          event_reading;
        logic [7:0]          event_threshold;
        logic [NUM_BITS-1:0] status_active;
        logic [NUM_BITS-1:0] status_context;
        logic                last;
    } result_t;

    typedef struct packed {
        logic [47:0]         threshold_levels;
        logic [7:0]          hyst_low;
        logic [7:0]          hyst_high;
        logic [15:0]         nominal_override;
        logic [7:0]          nominal_reading;
        logic                nominal_known;
        logic [NUM_BITS-1:0] assert_send_mask;
        logic [NUM_BITS-1:0] deassert_send_mask;
    } cfg_t;

    // one classified item: event masks to send plus the closing status
    typedef struct packed {
        logic [7:0]          reading;
        logic [NUM_BITS-1:0] deassert_events;
        logic [NUM_BITS-1:0] assert_events;
        logic [NUM_BITS-1:0] active;
        logic [NUM_BITS-1:0] context_bits;
    } job_t;

    function automatic logic [7:0] level_of(input logic [47:0] levels, input logic [3:0] bit_no);
        logic [7:0] lvl;
        case (bit_no[3:1])
            3'd0:    lvl = levels[7:0];
            3'd1:    lvl = levels[15:8];
            3'd2:    lvl = levels[23:16];
            3'd3:    lvl = levels[31:24];
            3'd4:    lvl = levels[39:32];
            3'd5:    lvl = levels[47:40];
            default: lvl = 8'd0;
        endcase
        return lvl;
    endfunction

    function automatic logic wants_assert(input logic [7:0] lvl, input logic odd,
                                          input logic [7:0] val);
        return odd ? (val >= lvl) : (val <= lvl);
    endfunction

    function automatic logic wants_deassert(input logic [7:0] lvl, input logic [7:0] hyst,
                                            input logic odd, input logic [7:0] val);
        logic signed [9:0] t;
        logic signed [9:0] h;
        logic signed [9:0] v;
        t = signed'({2'b00, lvl});
        h = signed'({2'b00, hyst});
        v = signed'({2'b00, val});
        return odd ? (v < (t - h)) : (v > (t + h));
    endfunction

endpackage

[hdl/teg_front.sv]
module teg_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            accept,
    input  teg_pkg::sample_t sample,
    input  teg_pkg::cfg_t   cfg,
    output teg_pkg::job_t   job
);

    localparam int NB = teg_pkg::NUM_BITS;

    logic [NB-1:0] active_reg, active_next;
    logic [NB-1:0] context_reg, context_next;

    logic [NB-1:0] nominal;
    logic [NB-1:0] nominalize;
    logic [NB-1:0] act0;
    logic [NB-1:0] fa_f;
    logic [NB-1:0] fd_f;
    logic [NB-1:0] act1;
    logic [NB-1:0] dev;
    logic [NB-1:0] aev;

    always_comb
    begin
        nominal = teg_pkg::DEFAULT_NOMINAL;
        if (cfg.nominal_override != teg_pkg::NO_OVERRIDE)
        begin
            nominal = cfg.nominal_override[NB-1:0];
        end
        else if (cfg.nominal_known)
        begin
            for (int b = 0; b < NB; b++)
            begin
                nominal[b] = teg_pkg::wants_assert(
                    teg_pkg::level_of(cfg.threshold_levels, 4'(b)), b[0],
                    cfg.nominal_reading);
            end
        end
    end

    always_comb
    begin
        logic [NB-1:0] ctx_in;
        logic [NB-1:0] blips;
        logic          as_b;
        logic          ds_b;
        logic [7:0]    lvl;
        ctx_in = sample.context_request;
        if (context_reg != ctx_in)
        begin
            nominalize = (context_reg ^ ctx_in) | ~ctx_in;
        end
        else
        begin
            nominalize = '0;
        end
        act0  = (active_reg & ~nominalize) | (nominalize & nominal);
        blips = sample.force_assert & sample.force_deassert;
        // forced events that would not change the bit are dropped, blips pass
        fa_f  = sample.force_assert & (blips | ~act0);
        fd_f  = sample.force_deassert & (blips | act0);
        for (int b = 0; b < NB; b++)
        begin
            lvl  = teg_pkg::level_of(cfg.threshold_levels, 4'(b));
            as_b = ctx_in[b] & ~act0[b] &
                   teg_pkg::wants_assert(lvl, b[0], sample.reading);
            ds_b = ctx_in[b] & act0[b] &
                   teg_pkg::wants_deassert(lvl, b[0] ? cfg.hyst_high : cfg.hyst_low,
                                           b[0], sample.reading);
            act1[b] = (act0[b] | as_b) & ~ds_b;
            dev[b]  = ctx_in[b] & (ds_b | fd_f[b]) & cfg.deassert_send_mask[b];
            aev[b]  = ctx_in[b] & (as_b | fa_f[b]) & cfg.assert_send_mask[b];
        end
    end

    always_comb
    begin
        job.reading         = sample.reading;
        job.deassert_events = '0;
        job.assert_events   = '0;
        if (sample.opcode == teg_pkg::OP_REARM)
        begin
            active_next  = '0;
            context_next = '0;
        end
        else if (!sample.reading_valid)
        begin
            active_next  = active_reg;
            context_next = '0;
        end
        else
        begin
            active_next         = act1;
            context_next        = sample.context_request;
            job.deassert_events = dev;
            job.assert_events   = aev;
        end
        job.active       = active_next;
        job.context_bits = context_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg  <= '0;
            context_reg <= '0;
        end
        else if (accept)
        begin
            active_reg  <= active_next;
            context_reg <= context_next;
        end
    end

endmodule

[hdl/teg_queue.sv]
module teg_queue #(
    parameter int DEPTH = teg_pkg::QUEUE_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  teg_pkg::job_t wr_job,
    output logic          full,
    input  logic          pop,
    output teg_pkg::job_t rd_job,
    output logic          empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    teg_pkg::job_t    slots_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == FULL_CNT);
    assign empty   = (count_reg == '0);
    assign do_push = push & ~full;
    assign do_pop  = pop & ~empty;
    assign rd_job  = slots_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots_reg[wr_ptr_reg] <= wr_job;
        end
    end

endmodule

[hdl/teg_back.sv]
module teg_back (
    input  logic             clk,
    input  logic             rst_n,
    input  teg_pkg::cfg_t    cfg,
    input  teg_pkg::job_t    q_job,
    input  logic             q_empty,
    output logic             q_pop,
    output teg_pkg::result_t result,
    output logic             empty,
    input  logic             pop
);

    localparam int NB = teg_pkg::NUM_BITS;
    localparam int PB = teg_pkg::PEND_BITS;
    localparam int IW = teg_pkg::PEND_IDX_W;

    logic             busy_reg, busy_next;
    logic [7:0]       reading_reg, reading_next;
    logic [PB-1:0]    pend_reg, pend_next;
    logic [NB-1:0]    active_reg, active_next;
    logic [NB-1:0]    context_reg, context_next;
    teg_pkg::result_t out_reg, out_next;
    logic             out_valid_reg, out_valid_next;

    logic             advance;
    logic [PB-1:0]    lowest;
    logic [IW-1:0]    idx;
    logic [PB-1:0]    job_pend;

    assign q_pop   = ~busy_reg & ~q_empty;
    assign advance = busy_reg & (~out_valid_reg | pop);
    assign result  = out_reg;
    assign empty   = ~out_valid_reg;

    // slot 2b is the deassertion of bit b, slot 2b+1 its assertion
    always_comb
    begin
        for (int b = 0; b < NB; b++)
        begin
            job_pend[2*b]     = q_job.deassert_events[b];
            job_pend[2*b + 1] = q_job.assert_events[b];
        end
    end

    always_comb
    begin
        lowest = pend_reg & (~pend_reg + 1'b1);
        idx    = '0;
        for (int i = 0; i < PB; i++)
        begin
            if (lowest[i])
            begin
                idx = idx | IW'(i);
            end
        end
    end

    always_comb
    begin
        busy_next      = busy_reg;
        reading_next   = reading_reg;
        pend_next      = pend_reg;
        active_next    = active_reg;
        context_next   = context_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg & ~pop;
        if (q_pop)
        begin
            busy_next    = 1'b1;
            reading_next = q_job.reading;
            pend_next    = job_pend;
            active_next  = q_job.active;
            context_next = q_job.context_bits;
        end
        else if (advance)
        begin
            out_valid_next = 1'b1;
            out_next       = '0;
            if (pend_reg != '0)
            begin
                out_next.kind            = teg_pkg::KIND_EVENT;
                out_next.event_offset    = idx[IW-1:1];
                out_next.direction       = idx[0] ? teg_pkg::DIR_ASSERT
                                                  : teg_pkg::DIR_DEASSERT;
                out_next.event_reading   = reading_reg;
                out_next.event_threshold = teg_pkg::level_of(cfg.threshold_levels,
                                                             idx[IW-1:1]);
                pend_next                = pend_reg & ~lowest;
            end
            else
            begin
                out_next.kind           = teg_pkg::KIND_STATUS;
                out_next.status_active  = active_reg;
                out_next.status_context = context_reg;
                out_next.last           = 1'b1;
                busy_next               = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        reading_reg <= reading_next;
        pend_reg    <= pend_next;
        active_reg  <= active_next;
        context_reg <= context_next;
        out_reg     <= out_next;
    end

endmodule

[hdl/threshold_event_generator.sv]
// Threshold event generator for an 8-bit threshold sensor.
// Input channel: a sample beat (opcode, reading, context and force masks) is
// taken when push is high and full is low. Result channel: while empty is low
// the oldest result is on the result port; pop takes it.
// Each update yields its deassert/assert event beats in bit order, deassert
// before assert per bit, then one status beat with last set. Rearm and
// invalid readings yield only the status beat.
// The front classifies a sample in the cycle it is pushed and updates the
// active/context state at once, so samples may be pushed every cycle until
// the job queue (QUEUE_DEPTH entries) fills.
// The back loads a job, then issues its beats in turn unless the output stalls;
// it takes the next job only after the status beat. A pushed item passes the
// queue slot, the back's job registers and the output register in that order.
// When pop stays low, the output register holds its beat, the back stops,
// the queue fills and full rises; nothing is dropped.
// Reset clears state, queue and output; configuration returns to defaults.
// Config is a 64-bit APB-style port, register i at byte address 8*i;
// write only while idle.
module threshold_event_generator #(
    parameter int QUEUE_DEPTH = teg_pkg::QUEUE_DEPTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  teg_pkg::sample_t              sample,
    output logic                          empty,
    input  logic                          pop,
    output teg_pkg::result_t              result,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [teg_pkg::ADDR_W-1:0]    paddr,
    input  logic [teg_pkg::DATA_W-1:0]    pwdata,
    output logic [teg_pkg::DATA_W-1:0]    prdata,
    output logic                          pready
);

    teg_pkg::cfg_t     cfg_reg;
    teg_pkg::reg_idx_t reg_idx;
    teg_pkg::job_t     front_job;
    teg_pkg::job_t     q_job;
    logic              q_empty;
    logic              q_pop;
    logic              accept;
    logic              cfg_write;

    assign pready    = 1'b1;
    assign reg_idx   = teg_pkg::reg_idx_t'(paddr[teg_pkg::ADDR_W-1:3]);
    assign cfg_write = psel & penable & pwrite;
    assign accept    = push & ~full;

    always_comb
    begin
        prdata = '0;
        unique case (reg_idx)
            teg_pkg::REG_THRESHOLD_LEVELS:   prdata = 64'(cfg_reg.threshold_levels);
            teg_pkg::REG_HYST_LOW:           prdata = 64'(cfg_reg.hyst_low);
            teg_pkg::REG_HYST_HIGH:          prdata = 64'(cfg_reg.hyst_high);
            teg_pkg::REG_NOMINAL_OVERRIDE:   prdata = 64'(cfg_reg.nominal_override);
            teg_pkg::REG_NOMINAL_READING:    prdata = 64'(cfg_reg.nominal_reading);
            teg_pkg::REG_NOMINAL_KNOWN:      prdata = 64'(cfg_reg.nominal_known);
            teg_pkg::REG_ASSERT_SEND_MASK:   prdata = 64'(cfg_reg.assert_send_mask);
            teg_pkg::REG_DEASSERT_SEND_MASK: prdata = 64'(cfg_reg.deassert_send_mask);
            default:                         prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.threshold_levels   <= teg_pkg::LEVELS_RESET;
            cfg_reg.hyst_low           <= '0;
            cfg_reg.hyst_high          <= '0;
            cfg_reg.nominal_override   <= teg_pkg::NO_OVERRIDE;
            cfg_reg.nominal_reading    <= '0;
            cfg_reg.nominal_known      <= 1'b0;
            cfg_reg.assert_send_mask   <= '0;
            cfg_reg.deassert_send_mask <= '0;
        end
        else if (cfg_write)
        begin
            unique case (reg_idx)
                teg_pkg::REG_THRESHOLD_LEVELS:   cfg_reg.threshold_levels   <= pwdata[47:0];
                teg_pkg::REG_HYST_LOW:           cfg_reg.hyst_low           <= pwdata[7:0];
                teg_pkg::REG_HYST_HIGH:          cfg_reg.hyst_high          <= pwdata[7:0];
                teg_pkg::REG_NOMINAL_OVERRIDE:   cfg_reg.nominal_override   <= pwdata[15:0];
                teg_pkg::REG_NOMINAL_READING:    cfg_reg.nominal_reading    <= pwdata[7:0];
                teg_pkg::REG_NOMINAL_KNOWN:      cfg_reg.nominal_known      <= pwdata[0];
                teg_pkg::REG_ASSERT_SEND_MASK:   cfg_reg.assert_send_mask   <= pwdata[11:0];
                teg_pkg::REG_DEASSERT_SEND_MASK: cfg_reg.deassert_send_mask <= pwdata[11:0];
                default:                         cfg_reg.nominal_known      <= cfg_reg.nominal_known;
            endcase
        end
    end

    teg_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .sample (sample),
        .cfg    (cfg_reg),
        .job    (front_job)
    );

    teg_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .wr_job (front_job),
        .full   (full),
        .pop    (q_pop),
        .rd_job (q_job),
        .empty  (q_empty)
    );

    teg_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .q_job   (q_job),
        .q_empty (q_empty),
        .q_pop   (q_pop),
        .result  (result),
        .empty   (empty),
        .pop     (pop)
    );

endmodule
